>>> hdl/bc_pkg.sv
// ----------------------------------------------------------------------------
// bc_pkg
// shared types, codes and alphabet functions of the base64 codec
// ----------------------------------------------------------------------------
package bc_pkg;

  localparam int unsigned QueueDepthDef = 4;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  localparam logic [1:0] PadNone = 2'd0;
  localparam logic [1:0] PadOne  = 2'd1;
  localparam logic [1:0] PadTwo  = 2'd2;

  localparam logic [7:0] CharPad = 8'h3D;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } bc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_data;
    logic       msg_end;
  } bc_out_t;

  // one unit of work handed from the front to the back
  typedef struct packed {
    logic        dec;
    logic        has;
    logic        last;
    logic [1:0]  pad;
    logic [23:0] data;
  } bc_job_t;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h47 + {2'b00, v};
    end else if (v < 6'd62) begin
      c = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  // msb is the valid flag, low six bits the value
  function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
    logic [7:0] t;
    logic [6:0] r;
    t = 8'h00;
    if (c inside {[8'h41:8'h5A]}) begin
      t = c - 8'h41;
      r = {1'b1, t[5:0]};
    end else if (c inside {[8'h61:8'h7A]}) begin
      t = c - 8'h47;
      r = {1'b1, t[5:0]};
    end else if (c inside {[8'h30:8'h39]}) begin
      t = c + 8'd4;
      r = {1'b1, t[5:0]};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage

>>> hdl/bc_front.sv
// ----------------------------------------------------------------------------
// bc_front
// takes input bytes, gathers encode groups or decode bits, issues jobs
// ----------------------------------------------------------------------------
module bc_front import bc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cfg_we_i,
  input  logic    cfg_wdata_i,
  input  logic    accept_i,
  input  bc_in_t  in_i,
  output logic    job_valid_o,
  output bc_job_t job_o
);

  logic        mode_q, mode_d;
  logic [15:0] acc_q, acc_d;
  logic [2:0]  held_q, held_d;

  logic [23:0] group;
  logic [6:0]  sx;
  logic [15:0] dacc;
  logic [3:0]  dbits;
  logic [3:0]  sh_full;
  logic [2:0]  sh;
  logic [15:0] dshift;
  logic [7:0]  dbyte;
  logic        emit;

  always_comb begin
    group   = {acc_q, in_i.in_byte};
    sx      = char_to_sextet(in_i.in_byte);
    dacc    = {acc_q[9:0], sx[5:0]};
    dbits   = {1'b0, held_q} + 4'd6;
    sh_full = dbits - 4'd8;
    sh      = sh_full[2:0];
    dshift  = dacc >> sh;
    dbyte   = dshift[7:0];
    emit    = sx[6] && (dbits >= 4'd8);
  end

  always_comb begin
    mode_d      = mode_q;
    acc_d       = acc_q;
    held_d      = held_q;
    job_valid_o = 1'b0;
    job_o       = '0;
    if (accept_i) begin
      if (mode_q == ModeEncode) begin
        if (held_q == 3'd2) begin
          job_valid_o = 1'b1;
          job_o.has   = 1'b1;
          job_o.last  = in_i.in_last;
          job_o.pad   = PadNone;
          job_o.data  = group;
          acc_d       = '0;
          held_d      = '0;
        end else if (!in_i.in_last) begin
          acc_d  = group[15:0];
          held_d = held_q + 3'd1;
        end else begin
          // short final group, left aligned
          job_valid_o = 1'b1;
          job_o.has   = 1'b1;
          job_o.last  = 1'b1;
          if (held_q == 3'd0) begin
            job_o.pad  = PadTwo;
            job_o.data = {in_i.in_byte, 16'h0000};
          end else begin
            job_o.pad  = PadOne;
            job_o.data = {acc_q[7:0], in_i.in_byte, 8'h00};
          end
          acc_d  = '0;
          held_d = '0;
        end
      end else begin
        if (sx[6]) begin
          acc_d  = dacc;
          held_d = emit ? sh : dbits[2:0];
        end
        if (emit || in_i.in_last) begin
          job_valid_o = 1'b1;
          job_o.dec   = 1'b1;
          job_o.has   = emit;
          job_o.last  = in_i.in_last;
          job_o.pad   = PadNone;
          job_o.data  = {16'h0000, emit ? dbyte : 8'h00};
        end
        if (in_i.in_last) begin
          acc_d  = '0;
          held_d = '0;
        end
      end
    end
    // a mode write drops any partial group
    if (cfg_we_i) begin
      mode_d = cfg_wdata_i;
      acc_d  = '0;
      held_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeEncode;
      acc_q  <= '0;
      held_q <= '0;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      held_q <= held_d;
    end
  end

endmodule

>>> hdl/bc_queue.sv
// ----------------------------------------------------------------------------
// bc_queue
// small job queue between the front and the back
// ----------------------------------------------------------------------------
module bc_queue import bc_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  bc_job_t wr_job_i,
  output logic    full_o,
  input  logic    rd_i,
  output bc_job_t rd_job_o,
  output logic    empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  bc_job_t         entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o   = (cnt_q == CntFull);
  assign empty_o  = (cnt_q == '0);
  assign rd_job_o = entries_q[rd_ptr_q];
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entries_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule

>>> hdl/bc_back.sv
// ----------------------------------------------------------------------------
// bc_back
// expands jobs into characters or bytes, one per cycle while output is free
// ----------------------------------------------------------------------------
module bc_back import bc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  bc_job_t q_job_i,
  output logic    q_rd_o,
  input  logic    pop_i,
  output logic    empty_o,
  output bc_out_t out_o
);

  bc_job_t    cur_q;
  logic       cur_valid_q;
  logic [1:0] idx_q;
  bc_out_t    out_q, res;
  logic       out_valid_q;

  logic       ready, fire, final_res;
  logic [5:0] sextet;
  logic [7:0] ch;

  always_comb begin
    case (idx_q)
      2'd0:    sextet = cur_q.data[23:18];
      2'd1:    sextet = cur_q.data[17:12];
      2'd2:    sextet = cur_q.data[11:6];
      default: sextet = cur_q.data[5:0];
    endcase
    ch = sextet_to_char(sextet);
    if ((cur_q.pad == PadTwo) && (idx_q >= 2'd2)) begin
      ch = CharPad;
    end else if ((cur_q.pad == PadOne) && (idx_q == 2'd3)) begin
      ch = CharPad;
    end
    if (cur_q.dec) begin
      res.out_byte = cur_q.data[7:0];
      res.has_data = cur_q.has;
      res.msg_end  = cur_q.last;
    end else begin
      res.out_byte = ch;
      res.has_data = 1'b1;
      res.msg_end  = cur_q.last && (idx_q == 2'd3);
    end
  end

  assign ready     = !out_valid_q || pop_i;
  assign fire      = ready && cur_valid_q;
  assign final_res = cur_q.dec || (idx_q == 2'd3);
  assign q_rd_o    = !q_empty_i && (!cur_valid_q || (fire && final_res));
  assign empty_o   = !out_valid_q;
  assign out_o     = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (q_rd_o) begin
        cur_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (fire && final_res) begin
        cur_valid_q <= 1'b0;
      end else if (fire) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      cur_q <= q_job_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

endmodule

>>> hdl/base64_codec_top.sv
// ----------------------------------------------------------------------------
// base64_codec_top
// streaming base64 encoder and decoder, standard alphabet
// ----------------------------------------------------------------------------
// input side looks like a queue: drive in_i and push while full is low; one
// message byte per transfer, in_last on the final byte of a message.
// result side likewise: while empty is low out_o holds the oldest result,
// pop takes it. cfg_we_i with cfg_wdata_i sets the mode (0 encode, 1 decode)
// and drops any partial group; write it only while the block is idle.
// each job passes through the job queue and the back's job register to out_q.
// throughput: the single output register gives one result per cycle while
// the receiver pops each result; encode gives four characters per three
// bytes. the front takes a new byte each cycle while the job queue
// (QueueDepth entries) has room.
// reset empties the queue and output, clears the held bits and selects
// encode. when the receiver stalls the output holds, the queue fills and
// full rises; nothing is lost.
// ----------------------------------------------------------------------------
module base64_codec_top import bc_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cfg_we_i,
  input  logic    cfg_wdata_i,
  input  logic    push,
  output logic    full,
  input  bc_in_t  in_i,
  input  logic    pop,
  output logic    empty,
  output bc_out_t out_o
);

  logic    accept;
  logic    job_valid;
  bc_job_t job;
  logic    q_rd, q_empty;
  bc_job_t q_job;

  assign accept = push && !full;

  bc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_i        (in_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  bc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (job_valid),
    .wr_job_i (job),
    .full_o   (full),
    .rd_i     (q_rd),
    .rd_job_o (q_job),
    .empty_o  (q_empty)
  );

  bc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_job_i   (q_job),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .out_o     (out_o)
  );

endmodule

>>> hdl/bc_checker.sv
// ----------------------------------------------------------------------------
// bc_checker
// port level checks of the base64 codec, bound to the top level
// ----------------------------------------------------------------------------
module bc_checker import bc_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    pop,
  input logic    empty,
  input bc_out_t out_o
);

  // a bare end marker carries a zero byte
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_o.has_data) |-> (out_o.out_byte == 8'h00))
    else $error("end marker with non-zero byte");

  // a result without data is only ever the end of a message
  a_marker_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_o.has_data) |-> out_o.msg_end)
    else $error("result without data that does not end the message");

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_o)))
    else $error("waiting result changed or vanished");

  // a result never appears on the output straight out of reset
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(empty) && !empty) |-> $past(rst_ni))
    else $error("result appeared straight out of reset");

endmodule

bind base64_codec_top bc_checker u_bc_checker (.*);
